// ===== rtl/frustum_box_culling_unit_macros.svh =====
// Assertion macros for the frustum box culling RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FRUSTUM_BOX_CULLING_UNIT_MACROS_SVH
`define FRUSTUM_BOX_CULLING_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FBC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fbc_pkg.sv =====
// Shared types, constants and helpers of the frustum box culling unit.
// No dependencies; imported by fbc_plane_cell and frustum_box_culling_unit.
package fbc_pkg;

    localparam int DEFAULT_ELEMENT_WIDTH = 24;
    localparam int PLANE_COUNT           = 6;
    localparam int COMPONENT_COUNT       = 4;
    localparam int COLUMN_INDEX_WIDTH    = 2;
    localparam int BOX_WIDTH             = 24;
    localparam int SIZE_WIDTH            = 23;
    localparam int CORNER_HI_WIDTH       = BOX_WIDTH + 1;
    localparam int FRAC_ALIGN            = 8;
    localparam int COMP_W                = 3;   // index of the w row in a column

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } command_t;

    // Control fields that travel with a transaction down the chain.
    typedef struct packed
    {
        command_t                        command;
        logic [COLUMN_INDEX_WIDTH-1:0]   column_index;
        logic                            culled;
    } ctrl_t;

    // Box as its minimum and maximum corners.
    typedef struct packed
    {
        logic signed [BOX_WIDTH-1:0]        lo_x;
        logic signed [BOX_WIDTH-1:0]        lo_y;
        logic signed [BOX_WIDTH-1:0]        lo_z;
        logic signed [CORNER_HI_WIDTH-1:0]  hi_x;
        logic signed [CORNER_HI_WIDTH-1:0]  hi_y;
        logic signed [CORNER_HI_WIDTH-1:0]  hi_z;
    } box_t;

    // Planes in order: w+x, w-x, w-y, w+y, w+z, w-z.
    function automatic logic plane_is_sub(input int plane);
        logic sub;
        case (plane)
            1, 2, 5: sub = 1'b1;
            default: sub = 1'b0;
        endcase
        return sub;
    endfunction

endpackage

// ===== rtl/fbc_plane_cell.sv =====
// One cell of the culling chain: holds one frustum plane and tests it.
// Depends on fbc_pkg and frustum_box_culling_unit_macros.svh.
`include "frustum_box_culling_unit_macros.svh"

module fbc_plane_cell
    import fbc_pkg::*;
#(
    parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH,
    parameter int PLANE         = 0
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  ctrl_t                           up_ctrl,
    input  logic signed [ELEMENT_WIDTH-1:0] up_entry [COMPONENT_COUNT],
    input  box_t                            up_box,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output ctrl_t                           dn_ctrl,
    output logic signed [ELEMENT_WIDTH-1:0] dn_entry [COMPONENT_COUNT],
    output box_t                            dn_box
);

    localparam int PW   = ELEMENT_WIDTH + 1;
    localparam int PRW  = PW + CORNER_HI_WIDTH;
    localparam int SW   = PRW + 2;
    localparam int AXIS = PLANE / 2;
    localparam logic SUB = plane_is_sub(PLANE);

    logic signed [PW-1:0]  plane_reg [COMPONENT_COUNT];
    logic signed [PW-1:0]  comp_next;

    logic                  a_valid_reg;
    ctrl_t                 a_ctrl_reg;
    logic signed [ELEMENT_WIDTH-1:0] a_entry_reg [COMPONENT_COUNT];
    box_t                  a_box_reg;
    logic signed [PRW-1:0] a_prod_x_reg, a_prod_y_reg, a_prod_z_reg;
    logic signed [PW-1:0]  a_konst_reg;

    logic signed [CORNER_HI_WIDTH-1:0] sel_x, sel_y, sel_z;
    logic signed [PRW-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [SW-1:0]  sum;

    logic                  b_valid_reg;
    ctrl_t                 b_ctrl_reg;
    ctrl_t                 b_ctrl_next;
    logic signed [ELEMENT_WIDTH-1:0] b_entry_reg [COMPONENT_COUNT];
    box_t                  b_box_reg;

    logic                  b_ready;
    logic                  up_take;
    logic                  a_move;
    logic                  load_take;

    assign b_ready   = !b_valid_reg || dn_ready;
    assign up_ready  = !a_valid_reg || b_ready;
    assign up_take   = up_valid && up_ready;
    assign a_move    = a_valid_reg && b_ready;
    assign load_take = up_take && (up_ctrl.command == CMD_LOAD);

    // Plane component from the incoming column: w plus or minus one row.
    always_comb
    begin
        if (SUB)
        begin
            comp_next = PW'(up_entry[COMP_W]) - PW'(up_entry[AXIS]);
        end
        else
        begin
            comp_next = PW'(up_entry[COMP_W]) + PW'(up_entry[AXIS]);
        end
    end

    // Farthest corner along the normal: min where the component is negative.
    always_comb
    begin
        sel_x = plane_reg[0][PW-1] ? CORNER_HI_WIDTH'(up_box.lo_x) : up_box.hi_x;
        sel_y = plane_reg[1][PW-1] ? CORNER_HI_WIDTH'(up_box.lo_y) : up_box.hi_y;
        sel_z = plane_reg[2][PW-1] ? CORNER_HI_WIDTH'(up_box.lo_z) : up_box.hi_z;
        prod_x_next = PRW'(plane_reg[0]) * PRW'(sel_x);
        prod_y_next = PRW'(plane_reg[1]) * PRW'(sel_y);
        prod_z_next = PRW'(plane_reg[2]) * PRW'(sel_z);
    end

    always_comb
    begin
        sum = SW'(a_prod_x_reg) + SW'(a_prod_y_reg) + SW'(a_prod_z_reg)
            + (SW'(a_konst_reg) <<< FRAC_ALIGN);
        b_ctrl_next = a_ctrl_reg;
        if (a_ctrl_reg.command == CMD_TEST && sum[SW-1])
        begin
            b_ctrl_next.culled = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COMPONENT_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (load_take)
        begin
            plane_reg[up_ctrl.column_index] <= comp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take)
        begin
            a_ctrl_reg   <= up_ctrl;
            a_entry_reg  <= up_entry;
            a_box_reg    <= up_box;
            a_prod_x_reg <= prod_x_next;
            a_prod_y_reg <= prod_y_next;
            a_prod_z_reg <= prod_z_next;
            a_konst_reg  <= plane_reg[COMP_W];
        end
        if (a_move)
        begin
            b_ctrl_reg  <= b_ctrl_next;
            b_entry_reg <= a_entry_reg;
            b_box_reg   <= a_box_reg;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_ctrl  = b_ctrl_reg;
    assign dn_entry = b_entry_reg;
    assign dn_box   = b_box_reg;

    `FBC_ASSERT_SAME(a_load_never_culled, clk, rst_n,
        b_valid_reg && b_ctrl_reg.command == CMD_LOAD, !b_ctrl_reg.culled,
        "load transaction carries a culled flag")
    `FBC_ASSERT_NEXT(a_culled_sticks, clk, rst_n,
        a_move && a_ctrl_reg.culled, b_ctrl_reg.culled,
        "culled flag dropped inside a cell")
    `FBC_ASSERT_NEXT(a_plane_holds, clk, rst_n,
        !load_take, $stable(plane_reg[0]) && $stable(plane_reg[1])
        && $stable(plane_reg[2]) && $stable(plane_reg[3]),
        "plane changed without a load transaction")
    `FBC_ASSERT_ALWAYS(a_stall_only_when_full, clk, rst_n,
        up_ready || (a_valid_reg && b_valid_reg),
        "cell stalled with an empty stage")

endmodule

// ===== rtl/frustum_box_culling_unit.sv =====
// Top level of the frustum box culling unit: a chain of six plane cells.
// Depends on fbc_pkg and fbc_plane_cell.
//
// Usage:
//   Item channel (item_valid/item_ready): command 0 loads one column of the
//   view-projection matrix (column_index, entry_x..entry_w, signed Q8.16);
//   command 1 tests a box (corner_x..z signed Q16.8, extent_x..z Q15.8).
//   Result channel (result_valid/result_ready): one transaction per item, in
//   order; is_test_answer tells a test answer from a load acknowledge, and
//   culled is set when the box lies fully outside some frustum plane.
// Pipeline: per plane cell, a multiply stage, then an add and sign stage.
// Throughput: one item per cycle, back to back, while result_ready is high;
//   each cell owns its plane and its three multipliers, so a load and a
//   following test never collide.
// Reset: all plane components clear to zero and the chain empties; a test
//   before any load sees zero planes and is not culled.
// Stall: when result_ready is low the last cell holds its result; earlier
//   cells keep advancing into free stages, and item_ready drops only once
//   every stage of the chain is full.
module frustum_box_culling_unit
    import fbc_pkg::*;
#(
    parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            command,
    input  logic [COLUMN_INDEX_WIDTH-1:0]   column_index,
    input  logic signed [ELEMENT_WIDTH-1:0] entry_x,
    input  logic signed [ELEMENT_WIDTH-1:0] entry_y,
    input  logic signed [ELEMENT_WIDTH-1:0] entry_z,
    input  logic signed [ELEMENT_WIDTH-1:0] entry_w,
    input  logic signed [BOX_WIDTH-1:0]     corner_x,
    input  logic signed [BOX_WIDTH-1:0]     corner_y,
    input  logic signed [BOX_WIDTH-1:0]     corner_z,
    input  logic [SIZE_WIDTH-1:0]           extent_x,
    input  logic [SIZE_WIDTH-1:0]           extent_y,
    input  logic [SIZE_WIDTH-1:0]           extent_z,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic                            is_test_answer,
    output logic                            culled
);

    // Link k feeds cell k; link PLANE_COUNT is the chain's output.
    logic                            link_valid [PLANE_COUNT+1];
    logic                            link_ready [PLANE_COUNT+1];
    ctrl_t                           link_ctrl  [PLANE_COUNT+1];
    logic signed [ELEMENT_WIDTH-1:0] link_entry [PLANE_COUNT+1][COMPONENT_COUNT];
    box_t                            link_box   [PLANE_COUNT+1];

    // Build the head transaction: start uncull'd, form the max corner exactly.
    always_comb
    begin
        link_valid[0]        = item_valid;
        link_ctrl[0].command = command_t'(command);
        link_ctrl[0].column_index = column_index;
        link_ctrl[0].culled  = 1'b0;
        link_entry[0][0]     = entry_x;
        link_entry[0][1]     = entry_y;
        link_entry[0][2]     = entry_z;
        link_entry[0][COMP_W] = entry_w;
        link_box[0].lo_x     = corner_x;
        link_box[0].lo_y     = corner_y;
        link_box[0].lo_z     = corner_z;
        link_box[0].hi_x     = CORNER_HI_WIDTH'(corner_x)
                             + $signed({2'b00, extent_x});
        link_box[0].hi_y     = CORNER_HI_WIDTH'(corner_y)
                             + $signed({2'b00, extent_y});
        link_box[0].hi_z     = CORNER_HI_WIDTH'(corner_z)
                             + $signed({2'b00, extent_z});
    end

    assign item_ready = link_ready[0];

    // One cell per plane; each advances the transaction and ORs in its test.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_cell
        fbc_plane_cell #(
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .PLANE         (p)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[p]),
            .up_ready (link_ready[p]),
            .up_ctrl  (link_ctrl[p]),
            .up_entry (link_entry[p]),
            .up_box   (link_box[p]),
            .dn_valid (link_valid[p+1]),
            .dn_ready (link_ready[p+1]),
            .dn_ctrl  (link_ctrl[p+1]),
            .dn_entry (link_entry[p+1]),
            .dn_box   (link_box[p+1])
        );
    end

    // The last cell's output stage is the result register.
    assign link_ready[PLANE_COUNT] = result_ready;
    assign result_valid   = link_valid[PLANE_COUNT];
    assign is_test_answer = (link_ctrl[PLANE_COUNT].command == CMD_TEST);
    assign culled         = link_ctrl[PLANE_COUNT].culled;

endmodule

// ===== verif/frustum_box_culling_unit_test.sv =====
// Testbench for frustum_box_culling_unit: matrix column loads and box culling tests.
// Depends on fbc_pkg and the unit's RTL; keeps its own plane store to predict
// every answer.
`timescale 1ns / 100ps

module frustum_box_culling_unit_test;
    import fbc_pkg::*;

    localparam int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH;
    localparam int PLANE_WIDTH   = ELEMENT_WIDTH + 1;
    localparam int STALL_PERCENT = 24;
    localparam int SETTLE_CYCLES = 30;       // idle clocks after the last answer before finishing
    localparam int RUN_LIMIT_NS  = 2_000_000;

    // Plane order in the store, four components (x, y, z, constant) per plane.
    localparam int PL_W_PLUS_X  = 0;
    localparam int PL_W_MINUS_X = 1;
    localparam int PL_W_MINUS_Y = 2;
    localparam int PL_W_PLUS_Y  = 3;
    localparam int PL_W_PLUS_Z  = 4;
    localparam int PL_W_MINUS_Z = 5;

    typedef struct {
        command_t                          command;
        logic [COLUMN_INDEX_WIDTH-1:0]     column_index;
        logic signed [ELEMENT_WIDTH-1:0]   entry_x;
        logic signed [ELEMENT_WIDTH-1:0]   entry_y;
        logic signed [ELEMENT_WIDTH-1:0]   entry_z;
        logic signed [ELEMENT_WIDTH-1:0]   entry_w;
        logic signed [BOX_WIDTH-1:0]       corner_x;
        logic signed [BOX_WIDTH-1:0]       corner_y;
        logic signed [BOX_WIDTH-1:0]       corner_z;
        logic [SIZE_WIDTH-1:0]             extent_x;
        logic [SIZE_WIDTH-1:0]             extent_y;
        logic [SIZE_WIDTH-1:0]             extent_z;
    } culling_item_t;

    typedef struct {
        logic is_test;
        logic culled;
    } answer_t;

    // DUT ports; the inputs driven here all start known at time zero.
    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            item_valid     = 1'b0;
    logic                            item_ready;
    logic                            command        = 1'b0;
    logic [COLUMN_INDEX_WIDTH-1:0]   column_index   = '0;
    logic signed [ELEMENT_WIDTH-1:0] entry_x        = '0;
    logic signed [ELEMENT_WIDTH-1:0] entry_y        = '0;
    logic signed [ELEMENT_WIDTH-1:0] entry_z        = '0;
    logic signed [ELEMENT_WIDTH-1:0] entry_w        = '0;
    logic signed [BOX_WIDTH-1:0]     corner_x       = '0;
    logic signed [BOX_WIDTH-1:0]     corner_y       = '0;
    logic signed [BOX_WIDTH-1:0]     corner_z       = '0;
    logic [SIZE_WIDTH-1:0]           extent_x       = '0;
    logic [SIZE_WIDTH-1:0]           extent_y       = '0;
    logic [SIZE_WIDTH-1:0]           extent_z       = '0;
    logic                            result_valid;
    logic                            result_ready   = 1'b0;
    logic                            is_test_answer;
    logic                            culled;

    // Predicted plane store, cleared like the block's at reset.
    logic signed [PLANE_WIDTH-1:0] plane_coeff [PLANE_COUNT*COMPONENT_COUNT] = '{default: '0};
    answer_t pending_answers [$];
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      answers_seen = 0;
    bit      steady_run   = 1'b0;   // when set, neither side idles

    frustum_box_culling_unit #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Write component col of all six planes from one matrix column.
    function automatic void load_planes(input culling_item_t it);
        longint x;
        longint y;
        longint z;
        longint w;
        int     col;
        x   = longint'(it.entry_x);
        y   = longint'(it.entry_y);
        z   = longint'(it.entry_z);
        w   = longint'(it.entry_w);
        col = int'(it.column_index);
        plane_coeff[PL_W_PLUS_X  * COMPONENT_COUNT + col] = PLANE_WIDTH'(w + x);
        plane_coeff[PL_W_MINUS_X * COMPONENT_COUNT + col] = PLANE_WIDTH'(w - x);
        plane_coeff[PL_W_MINUS_Y * COMPONENT_COUNT + col] = PLANE_WIDTH'(w - y);
        plane_coeff[PL_W_PLUS_Y  * COMPONENT_COUNT + col] = PLANE_WIDTH'(w + y);
        plane_coeff[PL_W_PLUS_Z  * COMPONENT_COUNT + col] = PLANE_WIDTH'(w + z);
        plane_coeff[PL_W_MINUS_Z * COMPONENT_COUNT + col] = PLANE_WIDTH'(w - z);
    endfunction

    // Exact plane test: pick the far corner per axis, cull on any negative sum.
    function automatic logic box_is_culled(input culling_item_t it);
        longint lo [3];
        longint hi [3];
        longint acc;
        longint n;
        logic   result;
        lo[0]  = longint'(it.corner_x);
        lo[1]  = longint'(it.corner_y);
        lo[2]  = longint'(it.corner_z);
        hi[0]  = lo[0] + longint'(it.extent_x);
        hi[1]  = lo[1] + longint'(it.extent_y);
        hi[2]  = lo[2] + longint'(it.extent_z);
        result = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            n   = longint'(plane_coeff[p * COMPONENT_COUNT + COMP_W]);
            acc = n * (longint'(1) << FRAC_ALIGN);
            for (int a = 0; a < 3; a++)
            begin
                n   = longint'(plane_coeff[p * COMPONENT_COUNT + a]);
                acc = acc + n * ((n < 0) ? lo[a] : hi[a]);
            end
            if (acc < 0)
                result = 1'b1;
        end
        return result;
    endfunction

    function automatic answer_t predict_answer(input culling_item_t it);
        answer_t ans;
        if (it.command == CMD_LOAD)
        begin
            load_planes(it);
            ans.is_test = 1'b0;
            ans.culled  = 1'b0;
        end
        else
        begin
            ans.is_test = 1'b1;
            ans.culled  = box_is_culled(it);
        end
        return ans;
    endfunction

    // ---------------------------------------------------------------
    // Random field generators: extremes, small values near zero, full range
    // ---------------------------------------------------------------

    function automatic logic signed [ELEMENT_WIDTH-1:0] rand_entry();
        logic signed [ELEMENT_WIDTH-1:0] v;
        case ($urandom_range(9))
            0:       v = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
            1:       v = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
            2:       v = '0;
            3, 4, 5: v = ELEMENT_WIDTH'($signed($urandom_range(1 << 18)) - (1 << 17));
            6:       v = ELEMENT_WIDTH'($signed($urandom_range(16)) - 8);
            default: v = ELEMENT_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic signed [BOX_WIDTH-1:0] rand_corner();
        logic signed [BOX_WIDTH-1:0] v;
        case ($urandom_range(9))
            0:       v = {1'b0, {(BOX_WIDTH-1){1'b1}}};
            1:       v = {1'b1, {(BOX_WIDTH-1){1'b0}}};
            2:       v = '0;
            3, 4, 5: v = BOX_WIDTH'($signed($urandom_range(1 << 13)) - (1 << 12));
            default: v = BOX_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [SIZE_WIDTH-1:0] rand_extent();
        logic [SIZE_WIDTH-1:0] v;
        case ($urandom_range(9))
            0:          v = '1;
            1:          v = '0;
            2, 3, 4, 5: v = SIZE_WIDTH'($urandom_range(1 << 12));
            default:    v = SIZE_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    // Fill every field, including the ones the command ignores.
    function automatic culling_item_t random_item(input command_t cmd,
                                                  input logic [COLUMN_INDEX_WIDTH-1:0] col);
        culling_item_t it;
        it.command      = cmd;
        it.column_index = col;
        it.entry_x      = rand_entry();
        it.entry_y      = rand_entry();
        it.entry_z      = rand_entry();
        it.entry_w      = rand_entry();
        it.corner_x     = rand_corner();
        it.corner_y     = rand_corner();
        it.corner_z     = rand_corner();
        it.extent_x     = rand_extent();
        it.extent_y     = rand_extent();
        it.extent_z     = rand_extent();
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Item channel driver, result channel receiver and checker
    // ---------------------------------------------------------------

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(input culling_item_t it);
        while (!steady_run && $urandom_range(99) < STALL_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        command      <= it.command;
        column_index <= it.column_index;
        entry_x      <= it.entry_x;
        entry_y      <= it.entry_y;
        entry_z      <= it.entry_z;
        entry_w      <= it.entry_w;
        corner_x     <= it.corner_x;
        corner_y     <= it.corner_y;
        corner_z     <= it.corner_z;
        extent_x     <= it.extent_x;
        extent_y     <= it.extent_y;
        extent_z     <= it.extent_z;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_answers.push_back(predict_answer(it));
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding answer is back.
    task automatic wait_all_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input int expected, input int observed);
        $display("mismatch at %0t, answer %0d: %s expected %0d got %0d",
                 $time, answers_seen, what, expected, observed);
        mismatches++;
    endtask

    always @(posedge clk)
        result_ready <= rst_n && (steady_run || $urandom_range(99) >= STALL_PERCENT);

    always @(posedge clk)
    begin : answer_check
        answer_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected result transaction", 0, 1);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (is_test_answer !== want.is_test)
                    report_mismatch("is_test_answer", int'(want.is_test),
                                    int'(is_test_answer));
                if (culled !== want.culled)
                    report_mismatch("culled", int'(want.culled), int'(culled));
            end
            answers_seen++;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Boxes against the cleared store: every plane is zero, so nothing culls.
    task automatic test_power_up_planes();
        culling_item_t it;
        it          = random_item(CMD_TEST, 2'd0);
        it.corner_x = {1'b1, {(BOX_WIDTH-1){1'b0}}};
        it.corner_y = {1'b1, {(BOX_WIDTH-1){1'b0}}};
        it.corner_z = {1'b1, {(BOX_WIDTH-1){1'b0}}};
        it.extent_x = '1;
        it.extent_y = '1;
        it.extent_z = '1;
        send_item(it);
        it.corner_x = {1'b0, {(BOX_WIDTH-1){1'b1}}};
        it.corner_y = {1'b0, {(BOX_WIDTH-1){1'b1}}};
        it.corner_z = {1'b0, {(BOX_WIDTH-1){1'b1}}};
        it.extent_x = '0;
        it.extent_y = '0;
        it.extent_z = '0;
        send_item(it);
    endtask

    // Unit x normal and constant -1 on every plane: sums land exactly on zero.
    // Columns 1 and 2 stay unloaded, so this also covers a partial matrix.
    task automatic test_zero_sum_boundary();
        culling_item_t it;
        it         = random_item(CMD_LOAD, 2'd0);
        it.entry_x = '0;
        it.entry_y = '0;
        it.entry_z = '0;
        it.entry_w = ELEMENT_WIDTH'(1);
        send_item(it);
        it              = random_item(CMD_LOAD, COLUMN_INDEX_WIDTH'(COMP_W));
        it.entry_x      = '0;
        it.entry_y      = '0;
        it.entry_z      = '0;
        it.entry_w      = ELEMENT_WIDTH'(-1);
        send_item(it);
        // hold the far x corner at exactly one unit, then one step below it
        it              = random_item(CMD_TEST, 2'd3);
        it.corner_x     = BOX_WIDTH'(256);
        it.extent_x     = '0;
        send_item(it);
        it.corner_x     = BOX_WIDTH'(255);
        send_item(it);
        it.corner_x     = '0;
        it.extent_x     = SIZE_WIDTH'(256);
        send_item(it);
    endtask

    // Full-scale columns and boxes at the field extremes, then all-minimum columns.
    task automatic test_entry_extremes();
        culling_item_t it;
        logic signed [ELEMENT_WIDTH-1:0] top;
        logic signed [ELEMENT_WIDTH-1:0] bottom;
        top    = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
        bottom = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
        for (int c = 0; c < COMPONENT_COUNT; c++)
        begin
            it         = random_item(CMD_LOAD, COLUMN_INDEX_WIDTH'(c));
            it.entry_x = (c % 2 == 0) ? top : bottom;
            it.entry_y = (c % 2 == 0) ? bottom : top;
            it.entry_z = (c < 2) ? top : bottom;
            it.entry_w = (c < 2) ? bottom : top;
            send_item(it);
        end
        it          = random_item(CMD_TEST, 2'd1);
        it.corner_x = {1'b0, {(BOX_WIDTH-1){1'b1}}};
        it.corner_y = {1'b1, {(BOX_WIDTH-1){1'b0}}};
        it.corner_z = {1'b0, {(BOX_WIDTH-1){1'b1}}};
        it.extent_x = '1;
        it.extent_y = '1;
        it.extent_z = '1;
        send_item(it);
        it.corner_x = {1'b1, {(BOX_WIDTH-1){1'b0}}};
        it.corner_y = {1'b0, {(BOX_WIDTH-1){1'b1}}};
        it.extent_x = '0;
        it.extent_z = '0;
        send_item(it);
        for (int c = 0; c < COMPONENT_COUNT; c++)
        begin
            it         = random_item(CMD_LOAD, COLUMN_INDEX_WIDTH'(c));
            it.entry_x = bottom;
            it.entry_y = bottom;
            it.entry_z = bottom;
            it.entry_w = bottom;
            send_item(it);
        end
        it          = random_item(CMD_TEST, 2'd2);
        it.corner_x = '0;
        it.corner_y = '0;
        it.corner_z = '0;
        send_item(it);
    endtask

    // Mostly whole matrices in rotated column order, forward or backward, the
    // rest one or two stray loads; each is followed by a batch of boxes.
    task automatic test_random_frames(input int budget);
        culling_item_t it;
        int   stop_at;
        int   boxes;
        logic [COLUMN_INDEX_WIDTH-1:0] base;
        bit   reverse;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            base    = COLUMN_INDEX_WIDTH'($urandom);
            reverse = 1'($urandom_range(1));
            if ($urandom_range(99) < 80)
            begin
                for (int k = 0; k < COMPONENT_COUNT; k++)
                    send_item(random_item(CMD_LOAD,
                        COLUMN_INDEX_WIDTH'(reverse ? base - k : base + k)));
            end
            else
            begin
                repeat ($urandom_range(2, 1))
                    send_item(random_item(CMD_LOAD, COLUMN_INDEX_WIDTH'($urandom)));
            end
            boxes = $urandom_range(14, 3);
            repeat (boxes)
                send_item(random_item(CMD_TEST, COLUMN_INDEX_WIDTH'($urandom)));
        end
    endtask

    // A long stretch with both sides always ready.
    task automatic test_back_to_back(input int budget);
        steady_run = 1'b1;
        test_random_frames(budget);
        steady_run = 1'b0;
    endtask

    // Let the pipeline drain completely, then resume on a warm store.
    task automatic test_pause_until_drained();
        test_random_frames(30);
        wait_all_results();
        test_random_frames(30);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_planes();
        test_zero_sum_boundary();
        test_entry_extremes();
        test_random_frames(600);
        test_back_to_back(300);
        test_pause_until_drained();
        test_random_frames(590);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("frustum_box_culling_unit_test: clean");
        else
            $display("frustum_box_culling_unit_test: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d answers outstanding", pending_answers.size());
        $display("frustum_box_culling_unit_test: errors");
        $finish;
    end

endmodule
